// ===== rtl/lsia_pkg.sv =====
// Shared types and fixed field widths for the linear scan id allocator.
// No dependencies; compiled first.
package lsia_pkg;

    // Fixed widths of the request and response fields
    localparam int ID_BITS       = 16;
    localparam int POS_IN_BITS   = 16;
    localparam int OUT_SLOT_BITS = 4;

    // One lifetime interval request
    typedef struct packed {
        logic                   new_run;
        logic [ID_BITS-1:0]     logic_id;
        logic [POS_IN_BITS-1:0] start_pos;
        logic [POS_IN_BITS-1:0] end_pos;
    } req_t;

    // One allocation response
    typedef struct packed {
        logic [ID_BITS-1:0]       logic_id_out;
        logic [OUT_SLOT_BITS-1:0] physical_id;
        logic [OUT_SLOT_BITS-1:0] max_id_used;
        logic                     overflow;
    } rsp_t;

    // Allocation status from the slot table to the top level
    typedef struct packed {
        logic [OUT_SLOT_BITS-1:0] physical_id;
        logic [OUT_SLOT_BITS-1:0] max_id_used;
        logic                     overflow;
    } alloc_status_t;

endpackage

// ===== rtl/lsia_req_if.sv =====
// Request channel interface: valid/ready handshake carrying lsia_pkg::req_t.
// Depends on lsia_pkg.
interface lsia_req_if;
    logic             valid;
    logic             ready;
    lsia_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lsia_rsp_if.sv =====
// Response channel interface: valid/ready handshake carrying lsia_pkg::rsp_t.
// Depends on lsia_pkg.
interface lsia_rsp_if;
    logic             valid;
    logic             ready;
    lsia_pkg::rsp_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/linear_scan_id_allocator_top.sv =====
// Top level of the linear scan id allocator: request register, slot table
// and response register. Depends on lsia_pkg, lsia_req_if, lsia_rsp_if,
// lsia_slot_table.
//
//   Channel  Dir  Payload          Notes
//   req      in   lsia_pkg::req_t  one lifetime interval, sorted by start
//   rsp      out  lsia_pkg::rsp_t  one allocation per request, in order
//
// Each request passes from acceptance to response through the request
// register, then the free/pick logic, into the response register. One
// request per cycle is sustained while rsp.ready holds; the table update and
// the next request's free/pick sit in the same loop through the table registers.
// Reset clears all slots and the maximum; no clearing pass is needed.
// A stalled response holds the response register; a request waiting behind
// it holds the request register and drops req.ready.
module linear_scan_id_allocator_top #(
    parameter int SLOT_COUNT = 16,
    parameter int POS_BITS   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lsia_req_if.sink  req,
    lsia_rsp_if.source rsp
);
    import lsia_pkg::*;

    logic          in_valid_reg;
    req_t          in_reg;
    logic          out_valid_reg;
    rsp_t          out_reg;
    logic          advance;
    alloc_status_t status;

    // Move the held request into the response register when it has room
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_reg <= req.payload;
        end
    end

    lsia_slot_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .POS_BITS   (POS_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .new_run   (in_reg.new_run),
        .start_pos (in_reg.start_pos),
        .end_pos   (in_reg.end_pos),
        .status    (status)
    );

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.logic_id_out <= in_reg.logic_id;
            out_reg.physical_id  <= status.physical_id;
            out_reg.max_id_used  <= status.max_id_used;
            out_reg.overflow     <= status.overflow;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // A request moved on always shows up as a response next cycle
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("response lost after request moved on");

    // A stalled response with a held request keeps the input closed
    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !rsp.ready |-> !req.ready)
        else $error("request accepted while pipeline stalled");

    // Overflow responses carry slot zero
    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.overflow |-> out_reg.physical_id == '0)
        else $error("overflow response with non-zero slot");

endmodule

// ===== rtl/lsia_slot_table.sv =====
// Slot table: busy bits, end positions and running maximum, with the
// combinational free / lowest-free pick / update logic. Depends on lsia_pkg.
module lsia_slot_table #(
    parameter int SLOT_COUNT = 16,
    parameter int POS_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            new_run,
    input  logic [lsia_pkg::POS_IN_BITS-1:0] start_pos,
    input  logic [lsia_pkg::POS_IN_BITS-1:0] end_pos,
    output lsia_pkg::alloc_status_t         status
);
    import lsia_pkg::*;

    localparam int SLOT_BITS = $clog2(SLOT_COUNT);

    logic [SLOT_COUNT-1:0] busy_reg;
    logic [SLOT_COUNT-1:0] busy_next;
    logic [POS_BITS-1:0]   end_reg [SLOT_COUNT];
    logic [SLOT_BITS-1:0]  max_reg;
    logic [SLOT_BITS-1:0]  max_next;

    logic [SLOT_COUNT-1:0] busy_eff;
    logic [SLOT_BITS-1:0]  max_eff;
    logic [SLOT_BITS-1:0]  pick;
    logic                  found;
    logic [POS_BITS-1:0]   start_w;
    logic [POS_BITS-1:0]   end_w;
    logic [31:0]           start_ext;
    logic [31:0]           end_ext;
    logic [31:0]           pick_ext;
    logic [31:0]           max_ext;

    // Positions reduced (or zero-extended) to the stored width
    assign start_ext = 32'(start_pos);
    assign end_ext   = 32'(end_pos);
    assign start_w   = start_ext[POS_BITS-1:0];
    assign end_w     = end_ext[POS_BITS-1:0];

    // Free expired slots; a new run sees an empty table
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            busy_eff[i] = !new_run && busy_reg[i] && !(end_reg[i] < start_w);
        end
        max_eff = new_run ? '0 : max_reg;
    end

    // Lowest free slot
    always_comb
    begin
        pick  = '0;
        found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!busy_eff[i])
            begin
                pick  = SLOT_BITS'(i);
                found = 1'b1;
            end
        end
    end

    // Next table state; nothing changes on overflow
    always_comb
    begin
        busy_next = busy_reg;
        max_next  = max_reg;
        if (found)
        begin
            busy_next       = busy_eff;
            busy_next[pick] = 1'b1;
            max_next        = (pick > max_eff) ? pick : max_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            max_reg  <= '0;
        end
        else if (step)
        begin
            busy_reg <= busy_next;
            max_reg  <= max_next;
        end
    end

    // End positions: payload only, valid through busy bits
    always_ff @(posedge clk)
    begin
        if (step && found)
        begin
            end_reg[pick] <= end_w;
        end
    end

    // Result fields wrap to four bits
    assign pick_ext = 32'(pick);
    assign max_ext  = 32'(max_next);

    assign status.physical_id = found ? pick_ext[OUT_SLOT_BITS-1:0] : '0;
    assign status.max_id_used = max_ext[OUT_SLOT_BITS-1:0];
    assign status.overflow    = !found;

    // A new run always lands in slot 0 with only that slot busy
    a_new_run_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        step && new_run |=> (max_reg == '0) && ($countones(busy_reg) == 1) && busy_reg[0])
        else $error("new run did not restart the table at slot 0");

    // A picked slot is busy in the following cycle
    a_pick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && found |=> busy_reg[$past(pick)])
        else $error("allocated slot not marked busy");

    // Overflow leaves the table untouched
    a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && !found |=> $stable(busy_reg) && $stable(max_reg))
        else $error("table changed on overflow");

endmodule
